### rtl/plim_pkg.sv
// ----------------------------------------------------------------------------
// plim_pkg: shared types and constants for the priority level interrupt masker
// Holds the source and level counts, field widths, operation codes and status
// codes.
// ----------------------------------------------------------------------------
package plim_pkg;

  // sizes of the source, level and nesting stores
  localparam int NumSources = 14;
  localparam int NumLevels  = 8;
  localparam int StackDepth = 8;

  // field widths
  localparam int SrcW    = 4;
  localparam int LevelW  = 3;
  localparam int MaskW   = 14;
  localparam int FuncW   = 2;
  localparam int StatusW = 2;
  localparam int StackW  = $clog2(StackDepth);
  localparam int NestW   = StackW + 1;

  // operation codes
  typedef enum logic [FuncW-1:0] {
    FuncAssign = 2'd0,
    FuncMask   = 2'd1,
    FuncEnter  = 2'd2,
    FuncExit   = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatusOk        = 2'd0,
    StatusStackFull = 2'd1,
    StatusStackEmpt = 2'd2
  } status_e;

endpackage

### rtl/priority_level_interrupt_masker.sv
// ----------------------------------------------------------------------------
// priority_level_interrupt_masker: nested priority interrupt masker
// Keeps a level per source and an enable row per level; assigns, masks,
// enters the lowest pending source with a nesting stack, and exits.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | in_valid_i / in_stall_o    | func, source, prio,
//          |           |                            | pending_bits
//  out     | output    | out_valid_o / out_stall_i  | enable_mask, ack_bits,
//          |           |                            | taken, taken_source,
//          |           |                            | active_level, status
//
// - one beat per cycle in and out while the output is not stalled; each beat
//   passes the input register, then the result register
// - the operation runs on the state while a beat moves from the input
//   register into the result register, so each beat sees the state left by
//   the one before it
// - reset clears the level table, the enable rows, the current level and the
//   nesting count; the saved level stack holds no reset value
// - a stall on the output holds the result and backs up into in_stall_o
//
module priority_level_interrupt_masker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [plim_pkg::FuncW-1:0]     func_i,
  input  logic [plim_pkg::SrcW-1:0]      source_i,
  input  logic [plim_pkg::LevelW-1:0]    prio_i,
  input  logic [plim_pkg::MaskW-1:0]     pending_bits_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [plim_pkg::MaskW-1:0]     enable_mask_o,
  output logic [plim_pkg::MaskW-1:0]     ack_bits_o,
  output logic                           taken_o,
  output logic [plim_pkg::SrcW-1:0]      taken_source_o,
  output logic [plim_pkg::LevelW-1:0]    active_level_o,
  output logic [plim_pkg::StatusW-1:0]   status_o
);

  // input register
  logic                          s1_valid_q;
  logic [plim_pkg::FuncW-1:0]    func_q;
  logic [plim_pkg::SrcW-1:0]     src_q;
  logic [plim_pkg::LevelW-1:0]   prio_q;
  logic [plim_pkg::MaskW-1:0]    pend_q;

  // block state
  logic [plim_pkg::LevelW-1:0]   sprio_q [plim_pkg::NumSources];
  logic [plim_pkg::LevelW-1:0]   sprio_d [plim_pkg::NumSources];
  logic [plim_pkg::MaskW-1:0]    rows_q  [plim_pkg::NumLevels];
  logic [plim_pkg::MaskW-1:0]    rows_d  [plim_pkg::NumLevels];
  logic [plim_pkg::LevelW-1:0]   saved_q [plim_pkg::StackDepth];
  logic [plim_pkg::LevelW-1:0]   cur_q, cur_d;
  logic [plim_pkg::NestW-1:0]    nest_q, nest_d;

  // result register
  logic                          out_valid_q;
  logic [plim_pkg::MaskW-1:0]    enable_q, enable_d;
  logic [plim_pkg::MaskW-1:0]    ack_q, ack_d;
  logic                          taken_q, taken_d;
  logic [plim_pkg::SrcW-1:0]     tsrc_q, tsrc_d;
  logic [plim_pkg::StatusW-1:0]  status_q, status_d;

  // handshake
  logic adv;
  logic in_acc;
  logic push_en;

  // beat moves from the input register to the result register
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // operation logic
  logic [plim_pkg::LevelW-1:0]  prio_sat;
  logic                         src_ok;
  logic [plim_pkg::MaskW-1:0]   pend_m;
  logic [plim_pkg::SrcW-1:0]    low_idx;
  logic [plim_pkg::SrcW-1:0]    rd_src;
  logic [plim_pkg::LevelW-1:0]  rd_prio;
  logic [plim_pkg::MaskW-1:0]   src_bit;

  always_comb begin
    sprio_d  = sprio_q;
    rows_d   = rows_q;
    cur_d    = cur_q;
    nest_d   = nest_q;
    push_en  = 1'b0;
    ack_d    = '0;
    taken_d  = 1'b0;
    tsrc_d   = '0;
    status_d = plim_pkg::StatusOk;

    // level saturation and source range
    if (32'(prio_q) >= plim_pkg::NumLevels) begin
      prio_sat = plim_pkg::LevelW'(plim_pkg::NumLevels - 1);
    end else begin
      prio_sat = prio_q;
    end
    src_ok  = 32'(src_q) < plim_pkg::NumSources;
    src_bit = plim_pkg::MaskW'(1) << src_q;

    // lowest pending source among the valid ones
    pend_m  = '0;
    low_idx = '0;
    for (int i = 0; i < plim_pkg::NumSources; i++) begin
      pend_m[i] = pend_q[i];
    end
    for (int i = plim_pkg::NumSources - 1; i >= 0; i--) begin
      if (pend_m[i]) begin
        low_idx = plim_pkg::SrcW'(i);
      end
    end

    // single read of the level table
    rd_src  = (plim_pkg::func_e'(func_q) == plim_pkg::FuncEnter) ? low_idx : src_q;
    rd_prio = src_ok || (plim_pkg::func_e'(func_q) == plim_pkg::FuncEnter) ?
              sprio_q[rd_src] : '0;

    unique case (plim_pkg::func_e'(func_q))
      plim_pkg::FuncAssign: begin
        if (src_ok) begin
          sprio_d[src_q] = prio_sat;
          for (int i = 0; i < plim_pkg::NumLevels; i++) begin
            if (i < 32'(prio_sat)) begin
              rows_d[i] = rows_q[i] | src_bit;
            end
          end
        end
      end
      plim_pkg::FuncMask: begin
        if (src_ok) begin
          sprio_d[src_q] = '0;
          for (int i = 0; i < plim_pkg::NumLevels; i++) begin
            if (i < 32'(rd_prio)) begin
              rows_d[i] = rows_q[i] & ~src_bit;
            end
          end
        end
      end
      plim_pkg::FuncEnter: begin
        if (pend_m != '0) begin
          if (32'(nest_q) >= plim_pkg::StackDepth) begin
            status_d = plim_pkg::StatusStackFull;
          end else begin
            push_en = 1'b1;
            nest_d  = nest_q + plim_pkg::NestW'(1);
            cur_d   = rd_prio;
            ack_d   = plim_pkg::MaskW'(1) << low_idx;
            taken_d = 1'b1;
            tsrc_d  = low_idx;
          end
        end
      end
      plim_pkg::FuncExit: begin
        if (nest_q == '0) begin
          status_d = plim_pkg::StatusStackEmpt;
        end else begin
          nest_d = nest_q - plim_pkg::NestW'(1);
          cur_d  = saved_q[nest_d[plim_pkg::StackW-1:0]];
        end
      end
      default: ;
    endcase

    // row of the level that is current after the operation
    enable_d = rows_d[cur_d];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      nest_q      <= '0;
      for (int i = 0; i < plim_pkg::NumSources; i++) begin
        sprio_q[i] <= '0;
      end
      for (int i = 0; i < plim_pkg::NumLevels; i++) begin
        rows_q[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        cur_q       <= cur_d;
        nest_q      <= nest_d;
        sprio_q     <= sprio_d;
        rows_q      <= rows_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers and nesting stack
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      src_q  <= source_i;
      prio_q <= prio_i;
      pend_q <= pending_bits_i;
    end
    if (adv) begin
      enable_q <= enable_d;
      ack_q    <= ack_d;
      taken_q  <= taken_d;
      tsrc_q   <= tsrc_d;
      status_q <= status_d;
      if (push_en) begin
        saved_q[nest_q[plim_pkg::StackW-1:0]] <= cur_q;
      end
    end
  end

  // outputs
  assign out_valid_o    = out_valid_q;
  assign enable_mask_o  = enable_q;
  assign ack_bits_o     = ack_q;
  assign taken_o        = taken_q;
  assign taken_source_o = tsrc_q;
  assign active_level_o = cur_q;
  assign status_o       = status_q;

  // checks
  a_ack_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && taken_q |-> $onehot(ack_q))
    else $error("taken beat without a one-hot acknowledge");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !taken_q |-> (ack_q == '0) && (tsrc_q == '0))
    else $error("acknowledge fields set on a beat that took nothing");

  a_nest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nest_q) <= plim_pkg::StackDepth)
    else $error("nesting count beyond stack depth");

  a_full_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == plim_pkg::StatusStackFull) |-> !taken_q)
    else $error("source taken with a full stack");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && push_en |=> (nest_q == $past(nest_q) + plim_pkg::NestW'(1)) && taken_q)
    else $error("push did not advance the nesting count");

endmodule

### tb/plim_mask_checker.sv
// ----------------------------------------------------------------------------
// plim_mask_checker: result checker for the priority level interrupt masker
// Watches both channels, runs its own copy of the level table, enable rows
// and nesting stack on every accepted input beat, and compares each output
// beat field by field against the oldest awaited result.
// ----------------------------------------------------------------------------
module plim_mask_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel, observed
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [plim_pkg::FuncW-1:0]     func_i,
  input  logic [plim_pkg::SrcW-1:0]      source_i,
  input  logic [plim_pkg::LevelW-1:0]    prio_i,
  input  logic [plim_pkg::MaskW-1:0]     pending_bits_i,
  // output channel, observed
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [plim_pkg::MaskW-1:0]     enable_mask_i,
  input  logic [plim_pkg::MaskW-1:0]     ack_bits_i,
  input  logic                           taken_i,
  input  logic [plim_pkg::SrcW-1:0]      taken_source_i,
  input  logic [plim_pkg::LevelW-1:0]    active_level_i,
  input  logic [plim_pkg::StatusW-1:0]   status_i,
  // run statistics
  output int                             errors_o,
  output int                             outstanding_o,
  output int                             checked_o,
  output int                             enters_taken_o,
  output int                             stack_full_o,
  output int                             stack_empty_o
);

  typedef struct packed {
    logic [plim_pkg::MaskW-1:0]  enable_mask;
    logic [plim_pkg::MaskW-1:0]  ack_bits;
    logic                        taken;
    logic [plim_pkg::SrcW-1:0]   taken_source;
    logic [plim_pkg::LevelW-1:0] active_level;
    plim_pkg::status_e           status;
  } mask_result_t;

  // predicted masker state
  logic [plim_pkg::LevelW-1:0] src_level [plim_pkg::NumSources];
  logic [plim_pkg::MaskW-1:0]  level_row [plim_pkg::NumLevels];
  logic [plim_pkg::LevelW-1:0] saved_lvl [plim_pkg::StackDepth];
  logic [plim_pkg::LevelW-1:0] cur_lvl;
  int unsigned                 depth;

  mask_result_t awaited_results [$];
  mask_result_t want;
  int errors, checked, enters_taken, stack_full, stack_empty;

  assign errors_o       = errors;
  assign checked_o      = checked;
  assign enters_taken_o = enters_taken;
  assign stack_full_o   = stack_full;
  assign stack_empty_o  = stack_empty;

  // apply one operation to the predicted state and build its result
  function automatic mask_result_t next_mask_result(
      input plim_pkg::func_e             op,
      input logic [plim_pkg::SrcW-1:0]   src,
      input logic [plim_pkg::LevelW-1:0] lvl,
      input logic [plim_pkg::MaskW-1:0]  pend);
    mask_result_t r;
    int unsigned first;
    r = '0;
    r.status = plim_pkg::StatusOk;
    first = 0;
    // a 3-bit level never exceeds the top row, so no saturation is needed
    case (op)
      plim_pkg::FuncAssign: begin
        if (src < plim_pkg::NumSources) begin
          src_level[src] = lvl;
          for (int i = 0; i < plim_pkg::NumLevels; i++)
            if (i < lvl) level_row[i][src] = 1'b1;
        end
      end
      plim_pkg::FuncMask: begin
        if (src < plim_pkg::NumSources) begin
          for (int i = 0; i < plim_pkg::NumLevels; i++)
            if (i < src_level[src]) level_row[i][src] = 1'b0;
          src_level[src] = '0;
        end
      end
      plim_pkg::FuncEnter: begin
        // lowest pending bit wins, regardless of the enable row
        if (pend != '0) begin
          while (!pend[first]) first++;
          if (depth >= plim_pkg::StackDepth) begin
            r.status = plim_pkg::StatusStackFull;
          end else begin
            saved_lvl[depth] = cur_lvl;
            depth++;
            cur_lvl = src_level[first];
            r.ack_bits[first] = 1'b1;
            r.taken = 1'b1;
            r.taken_source = first[plim_pkg::SrcW-1:0];
          end
        end
      end
      plim_pkg::FuncExit: begin
        if (depth == 0) begin
          r.status = plim_pkg::StatusStackEmpt;
        end else begin
          depth--;
          cur_lvl = saved_lvl[depth];
        end
      end
      default: ;
    endcase
    r.enable_mask  = level_row[cur_lvl];
    r.active_level = cur_lvl;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val,
               got_val);
      errors++;
    end
  endtask

  // compare output beats, then predict input beats, at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < plim_pkg::NumSources; i++) src_level[i] = '0;
      for (int i = 0; i < plim_pkg::NumLevels; i++) level_row[i] = '0;
      for (int i = 0; i < plim_pkg::StackDepth; i++) saved_lvl[i] = '0;
      cur_lvl = '0;
      depth = 0;
      awaited_results.delete();
      errors = 0;
      checked = 0;
      enters_taken = 0;
      stack_full = 0;
      stack_empty = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with none expected, enable_mask 0x%0h status %0d",
                   $time, enable_mask_i, status_i);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("enable_mask", want.enable_mask, enable_mask_i);
          check_field("ack_bits", want.ack_bits, ack_bits_i);
          check_field("taken", want.taken, taken_i);
          check_field("taken_source", want.taken_source, taken_source_i);
          check_field("active_level", want.active_level, active_level_i);
          check_field("status", want.status, status_i);
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = next_mask_result(plim_pkg::func_e'(func_i), source_i, prio_i,
                                pending_bits_i);
        awaited_results.push_back(want);
        if (want.taken) enters_taken++;
        if (want.status == plim_pkg::StatusStackFull) stack_full++;
        if (want.status == plim_pkg::StatusStackEmpt) stack_empty++;
      end
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

### tb/tb_priority_level_interrupt_masker.sv
// ----------------------------------------------------------------------------
// tb_priority_level_interrupt_masker: testbench for the interrupt masker
// Drives directed operations covering the corner cases, then phases of random
// assign, mask, enter and exit traffic with random gaps and output stalls;
// a separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_priority_level_interrupt_masker;

  localparam int RandomOps     = 1750;
  localparam int TimeoutCycles = 300_000;

  // operation mixes of the random phases
  localparam int unsigned MixBalanced = 0;
  localparam int unsigned MixNesting  = 1;
  localparam int unsigned MixUnwind   = 2;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [plim_pkg::FuncW-1:0]    func_i;
  logic [plim_pkg::SrcW-1:0]     source_i;
  logic [plim_pkg::LevelW-1:0]   prio_i;
  logic [plim_pkg::MaskW-1:0]    pending_bits_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [plim_pkg::MaskW-1:0]    enable_mask_o;
  logic [plim_pkg::MaskW-1:0]    ack_bits_o;
  logic                          taken_o;
  logic [plim_pkg::SrcW-1:0]     taken_source_o;
  logic [plim_pkg::LevelW-1:0]   active_level_o;
  logic [plim_pkg::StatusW-1:0]  status_o;

  int errors, outstanding, checked, enters_taken, stack_full, stack_empty;
  int ops_driven;
  bit sender_quiet;

  priority_level_interrupt_masker dut (.*);

  plim_mask_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .func_i         (func_i),
    .source_i       (source_i),
    .prio_i         (prio_i),
    .pending_bits_i (pending_bits_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .enable_mask_i  (enable_mask_o),
    .ack_bits_i     (ack_bits_o),
    .taken_i        (taken_o),
    .taken_source_i (taken_source_o),
    .active_level_i (active_level_o),
    .status_i       (status_o),
    .errors_o       (errors),
    .outstanding_o  (outstanding),
    .checked_o      (checked),
    .enters_taken_o (enters_taken),
    .stack_full_o   (stack_full),
    .stack_empty_o  (stack_empty)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // offer one input beat after a random gap and wait for it to be taken
  task automatic drive_op(input plim_pkg::func_e op,
                          input logic [plim_pkg::SrcW-1:0] src,
                          input logic [plim_pkg::LevelW-1:0] lvl,
                          input logic [plim_pkg::MaskW-1:0] pend);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= op;
    source_i       <= src;
    prio_i         <= lvl;
    pending_bits_i <= pend;
    do @(posedge clk_i); while (in_stall_o);
    ops_driven++;
  endtask

  // hold the sender until every awaited result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // operation mix: balanced, nesting deeper, or unwinding
  function automatic plim_pkg::func_e pick_op(input int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MixNesting: return roll < 20 ? plim_pkg::FuncAssign :
                         roll < 30 ? plim_pkg::FuncMask :
                         roll < 85 ? plim_pkg::FuncEnter : plim_pkg::FuncExit;
      MixUnwind: return roll < 20 ? plim_pkg::FuncAssign :
                        roll < 30 ? plim_pkg::FuncMask :
                        roll < 45 ? plim_pkg::FuncEnter : plim_pkg::FuncExit;
      default: return roll < 30 ? plim_pkg::FuncAssign :
                      roll < 45 ? plim_pkg::FuncMask :
                      roll < 75 ? plim_pkg::FuncEnter : plim_pkg::FuncExit;
    endcase
  endfunction

  // pending flags: none, a single source, or a random spread
  function automatic logic [plim_pkg::MaskW-1:0] pick_pending();
    int unsigned roll;
    logic [plim_pkg::MaskW-1:0] bits;
    roll = $urandom_range(0, 9);
    bits = '0;
    if (roll == 0) bits = '0;
    else if (roll < 5) bits[$urandom_range(0, plim_pkg::NumSources - 1)] = 1'b1;
    else bits = plim_pkg::MaskW'($urandom_range(1, 14'h3fff));
    return bits;
  endfunction

  // reset, directed corner cases, random phases, drain and verdict
  initial begin
    int unsigned mode;
    logic [plim_pkg::SrcW-1:0] src;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    func_i         <= plim_pkg::FuncAssign;
    source_i       <= '0;
    prio_i         <= '0;
    pending_bits_i <= '0;
    out_stall_i    <= 1'b0;
    ops_driven     = 0;
    sender_quiet   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty stack and nothing pending
    drive_op(plim_pkg::FuncExit, 4'd0, 3'd0, 14'h0000);
    drive_op(plim_pkg::FuncEnter, 4'd15, 3'd7, 14'h0000);
    // extreme levels and sources, out-of-range sources do nothing
    drive_op(plim_pkg::FuncAssign, 4'd0, 3'd7, 14'h0000);
    drive_op(plim_pkg::FuncAssign, 4'd13, 3'd1, 14'h3fff);
    drive_op(plim_pkg::FuncAssign, 4'd14, 3'd5, 14'h0000);
    drive_op(plim_pkg::FuncAssign, 4'd15, 3'd7, 14'h3fff);
    drive_op(plim_pkg::FuncMask, 4'd15, 3'd0, 14'h0000);
    drive_op(plim_pkg::FuncAssign, 4'd5, 3'd0, 14'h0000);
    // lowest pending wins, enable rows do not filter
    drive_op(plim_pkg::FuncEnter, 4'd0, 3'd0, 14'h3fff);
    drive_op(plim_pkg::FuncEnter, 4'd0, 3'd0, 14'h2000);
    // fill the nesting stack, then overflow it
    repeat (6) drive_op(plim_pkg::FuncEnter, 4'd0, 3'd0, 14'h0020);
    drive_op(plim_pkg::FuncEnter, 4'd0, 3'd0, 14'h0001);
    drive_op(plim_pkg::FuncExit, 4'd0, 3'd0, 14'h0000);
    drive_op(plim_pkg::FuncExit, 4'd0, 3'd0, 14'h0000);
    // reassign lower leaves the old upper rows set, then mask
    drive_op(plim_pkg::FuncAssign, 4'd0, 3'd2, 14'h0000);
    drive_op(plim_pkg::FuncMask, 4'd0, 3'd0, 14'h0000);
    drive_op(plim_pkg::FuncMask, 4'd13, 3'd7, 14'h0000);

    // random phases of 50 beats each
    mode = MixBalanced;
    for (int n = 0; n < RandomOps; n++) begin
      if (n % 50 == 0) begin
        mode = $urandom_range(MixBalanced, MixUnwind);
        sender_quiet = ($urandom_range(0, 3) == 0);
      end
      if (n == 800) wait_drained();
      if ($urandom_range(0, 9) == 0) src = plim_pkg::SrcW'($urandom_range(14, 15));
      else src = plim_pkg::SrcW'($urandom_range(0, plim_pkg::NumSources - 1));
      drive_op(pick_op(mode), src, plim_pkg::LevelW'($urandom_range(0, 7)),
               pick_pending());
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d operations driven, %0d results checked", ops_driven, checked);
    $display("nesting: %0d enters taken, %0d stack overflows, %0d empty exits",
             enters_taken, stack_full, stack_empty);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result receiver: random stalls, quiet stretches and two long hold-offs
  initial begin
    int unsigned beats, hold;
    beats = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (beats == 300 || beats == 1100) hold = 90;
      else if ((beats / 150) % 4 == 1) hold = 0;
      else hold = $urandom_range(0, 12);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      beats++;
    end
  end

  // watchdog
  initial begin
    #(TimeoutCycles * 20);
    $display("TEST FAILED");
    $finish;
  end

endmodule
